FILE: design/mxh_pkg.sv
// Shared types, constants and start values for the multiply-xor hash.
package mxh_pkg;

  localparam int LANES = 4;
  localparam int WORD_W = 64;
  localparam int HALF_W = 32;

  localparam logic [1:0] REQ_BEGIN = 2'd0;
  localparam logic [1:0] REQ_WORD  = 2'd1;
  localparam logic [1:0] REQ_END   = 2'd2;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [1:0] lane_idx_t;

  typedef struct packed {
    logic [1:0] req_type;
    word_t      data_word;
  } in_t;

  typedef struct packed {
    word_t digest_a;
    word_t digest_b;
    word_t digest_c;
    word_t digest_d;
  } out_t;

  function automatic word_t lane_prime(input lane_idx_t idx);
    word_t p;
    case (idx)
      2'd0:    p = 64'd11111111111111111027;
      2'd1:    p = 64'd9999999999999999961;
      2'd2:    p = 64'd7777777777777777687;
      default: p = 64'd5555555555555555533;
    endcase
    return p;
  endfunction

  function automatic word_t result_start(input lane_idx_t idx);
    word_t v;
    case (idx)
      2'd0:    v = 64'd8888888888888888881;
      2'd1:    v = 64'd6666666666666666619;
      2'd2:    v = 64'd4444444444444444409;
      default: v = 64'd2222222222222222177;
    endcase
    return v;
  endfunction

  function automatic word_t sum_start(input lane_idx_t idx);
    word_t v;
    case (idx)
      2'd0:    v = 64'd7777777777777777687;
      2'd1:    v = 64'd5555555555555555533;
      2'd2:    v = 64'd3333333333333333271;
      default: v = 64'd1111111111111111037;
    endcase
    return v;
  endfunction

endpackage

FILE: design/mxh_lane.sv
// One hash lane: xor the word in, 64x64 multiply from 32x32 partial products, add high half.
module mxh_lane (
  input  mxh_pkg::word_t res,
  input  mxh_pkg::word_t sum,
  input  mxh_pkg::word_t word,
  input  mxh_pkg::word_t prime,
  output mxh_pkg::word_t lo,
  output mxh_pkg::word_t sum_nxt
);
  import mxh_pkg::*;

  word_t             x;
  logic [HALF_W-1:0] xl, xh, yl, yh;
  word_t             p0, p1, p2, p3;
  logic [HALF_W+1:0] mid;
  word_t             hi;

  assign x  = res ^ word;
  assign xl = x[HALF_W-1:0];
  assign xh = x[WORD_W-1:HALF_W];
  assign yl = prime[HALF_W-1:0];
  assign yh = prime[WORD_W-1:HALF_W];

  assign p0 = word_t'(xl) * word_t'(yl);
  assign p1 = word_t'(xh) * word_t'(yl);
  assign p2 = word_t'(xl) * word_t'(yh);
  assign p3 = word_t'(xh) * word_t'(yh);

  // cross term: carry out of the low half lands in mid's top two bits
  assign mid = {2'b00, p0[WORD_W-1:HALF_W]} + {2'b00, p1[HALF_W-1:0]}
             + {2'b00, p2[HALF_W-1:0]};

  assign lo = {mid[HALF_W-1:0], p0[HALF_W-1:0]};
  assign hi = p3 + word_t'(p1[WORD_W-1:HALF_W]) + word_t'(p2[WORD_W-1:HALF_W])
            + word_t'(mid[HALF_W+1:HALF_W]);

  assign sum_nxt = sum + hi;

endmodule

FILE: design/mxh_out_reg.sv
// Digest output register; holds a result until the downstream transfer completes.
module mxh_out_reg (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          load,
  input  mxh_pkg::out_t load_data,
  output logic          out_valid,
  input  logic          out_stall,
  output mxh_pkg::out_t out_data
);
  import mxh_pkg::*;

  logic out_valid_r;
  out_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= load_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: design/multiply_xor_hash_256.sv
// Top level: 256-bit multiply-xor hash over 64-bit words, four lanes.
// Throughput: one request per cycle, begin, word or end, back to back while
//   no end stalls; the limit is the per-lane multiply-add feedback through the lane state.
// Output: the end request passes the input register, then the output register,
//   before the digest is valid; an end waits while a digest sits stalled.
// Reset: lane results and sums load their start constants, valids clear.
module multiply_xor_hash_256 (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  mxh_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output mxh_pkg::out_t out_data
);
  import mxh_pkg::*;

  logic  s1_valid_r;
  in_t   s1_r;
  logic  s1_end;
  logic  s1_fire;
  word_t result_r [LANES];
  word_t sum_r    [LANES];
  word_t lo       [LANES];
  word_t sum_nxt  [LANES];
  word_t result_nxt [LANES];
  out_t  digest;

  assign s1_end = (s1_r.req_type == REQ_END);
  // only an end with a full, stalled output register can block
  assign in_stall = s1_valid_r && s1_end && out_valid && out_stall;
  assign s1_fire  = s1_valid_r && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_r <= in_data;
    end
  end

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    mxh_lane u_lane (
      .res     (result_r[g]),
      .sum     (sum_r[g]),
      .word    (s1_r.data_word),
      .prime   (lane_prime(lane_idx_t'(g))),
      .lo      (lo[g]),
      .sum_nxt (sum_nxt[g])
    );
    // each lane mixes in the previous lane's updated sum
    assign result_nxt[g] = lo[g] ^ sum_nxt[(g + LANES - 1) % LANES];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LANES; i++) begin
        result_r[i] <= result_start(lane_idx_t'(i));
        sum_r[i]    <= sum_start(lane_idx_t'(i));
      end
    end else if (s1_fire) begin
      case (s1_r.req_type)
        REQ_BEGIN: begin
          for (int i = 0; i < LANES; i++) begin
            result_r[i] <= result_start(lane_idx_t'(i));
            sum_r[i]    <= sum_start(lane_idx_t'(i));
          end
        end
        REQ_WORD: begin
          for (int i = 0; i < LANES; i++) begin
            result_r[i] <= result_nxt[i];
            sum_r[i]    <= sum_nxt[i];
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign digest.digest_a = result_r[0];
  assign digest.digest_b = result_r[1];
  assign digest.digest_c = result_r[2];
  assign digest.digest_d = result_r[3];

  mxh_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (s1_fire && s1_end),
    .load_data (digest),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
